// File: rtl/mi_snoop_coherence_defines.svh
// Assertion macros for the MI snooping coherence block.
// Used by the top level only; no other dependencies.
`ifndef MI_SNOOP_COHERENCE_DEFINES_SVH
`define MI_SNOOP_COHERENCE_DEFINES_SVH

`ifndef SYNTH
`define MIS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MIS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/mis_pkg.sv
// Shared types and default sizes for the MI snooping coherence block.
// No dependencies.
`default_nettype none

package mis_pkg;

    localparam int unsigned NUM_CACHES_DEF = 2;
    localparam int unsigned ADDR_BITS_DEF  = 8;
    localparam int unsigned DATA_BITS_DEF  = 32;

    typedef enum logic [1:0] {
        BUS_NONE = 2'd0,
        BUS_GETS = 2'd1,
        BUS_GETM = 2'd2
    } bus_op_t;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

endpackage

`default_nettype wire

// File: rtl/mi_snoop_coherence.sv
// MI snooping coherence controller: line state and data in two block memories.
// Depends on mis_pkg and mi_snoop_coherence_defines.svh.
`default_nettype none

`include "mi_snoop_coherence_defines.svh"

// The block accepts one request per cycle unless the output stalls and returns one result
// per request, in order, through the stage-1 and output registers. Line state lives in a
// memory with one row per address that holds a Modified bit for every cache, and the line
// data lives in a second memory with one word per address, because the protocol keeps at
// most one Modified copy of any line. Each request reads its row when it is accepted and
// writes the row back when it leaves stage 1; a request that follows one to the same
// address takes the updated row from a forwarding register. After reset a clearing pass
// writes every state row to Invalid, one row per cycle; s_tready stays low during it.
module mi_snoop_coherence
    import mis_pkg::*;
#(
    parameter int unsigned NUM_CACHES = NUM_CACHES_DEF,
    parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
    parameter int unsigned DATA_BITS  = DATA_BITS_DEF,
    localparam int unsigned ID_BITS   = (NUM_CACHES > 2) ? $clog2(NUM_CACHES) : 1,
    localparam int unsigned S_RAW_W   = ID_BITS + ADDR_BITS + DATA_BITS,
    localparam int unsigned S_TDATA_W = ((S_RAW_W + 7) / 8) * 8,
    localparam int unsigned M_RAW_W   = 5 + ID_BITS + DATA_BITS + NUM_CACHES - 1,
    localparam int unsigned M_TDATA_W = ((M_RAW_W + 7) / 8) * 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // cache_id, address, write_data
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // hit, bus_op, writeback_valid, writeback_source, writeback_data, invalidated_mask
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int unsigned LINES    = 1 << ADDR_BITS;
    localparam int unsigned ADDR_LSB = ID_BITS;
    localparam int unsigned DATA_LSB = ID_BITS + ADDR_BITS;

    logic [NUM_CACHES-1:0] mask_mem [LINES];
    logic [DATA_BITS-1:0]  data_mem [LINES];

    logic                  clearing_reg;
    logic [ADDR_BITS-1:0]  clr_cnt_reg;
    logic                  st1_valid_reg;
    logic                  st1_write_reg;
    logic [ID_BITS-1:0]    st1_id_reg;
    logic [ADDR_BITS-1:0]  st1_addr_reg;
    logic [DATA_BITS-1:0]  st1_wdata_reg;
    logic [NUM_CACHES-1:0] mask_rd_reg;
    logic [DATA_BITS-1:0]  data_rd_reg;
    logic                  fwd_valid_reg;
    logic [NUM_CACHES-1:0] fwd_mask_reg;
    logic [DATA_BITS-1:0]  fwd_data_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic                  in_write;
    logic [ID_BITS-1:0]    in_id;
    logic [ADDR_BITS-1:0]  in_addr;
    logic [DATA_BITS-1:0]  in_wdata;
    logic                  accept;
    logic                  out_free;
    logic                  st1_go;

    logic                  id_ok;
    logic [NUM_CACHES-1:0] me_onehot;
    logic [NUM_CACHES-1:0] eff_mask;
    logic [DATA_BITS-1:0]  eff_data;
    logic [NUM_CACHES-1:0] others;
    logic                  res_hit;
    bus_op_t               res_op;
    logic                  res_wbv;
    logic [ID_BITS-1:0]    res_wbs;
    logic [DATA_BITS-1:0]  res_wbd;
    logic [NUM_CACHES-1:0] res_inval;
    logic [NUM_CACHES-1:0] new_mask;
    logic [DATA_BITS-1:0]  new_data;
    logic                  data_we;

    logic                  mask_we;
    logic [ADDR_BITS-1:0]  mask_wr_addr;
    logic [NUM_CACHES-1:0] mask_wr_data;

    assign in_write = s_tuser;
    assign in_id    = s_tdata[ID_BITS-1:0];
    assign in_addr  = s_tdata[ADDR_LSB +: ADDR_BITS];
    assign in_wdata = s_tdata[DATA_LSB +: DATA_BITS];

    assign out_free = !m_tvalid_reg || m_tready;
    assign st1_go   = st1_valid_reg && out_free;
    assign s_tready = !clearing_reg && (!st1_valid_reg || st1_go);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A request id beyond the last cache is answered with an all-zero result.
    assign id_ok     = {1'b0, st1_id_reg} < (ID_BITS + 1)'(NUM_CACHES);
    assign me_onehot = NUM_CACHES'(1) << st1_id_reg;
    assign eff_mask  = fwd_valid_reg ? fwd_mask_reg : mask_rd_reg;
    assign eff_data  = fwd_valid_reg ? fwd_data_reg : data_rd_reg;
    assign others    = eff_mask & ~me_onehot;

    always_comb
    begin
        res_hit   = 1'b0;
        res_op    = BUS_NONE;
        res_wbv   = 1'b0;
        res_wbs   = '0;
        res_wbd   = '0;
        res_inval = '0;
        new_mask  = eff_mask;
        new_data  = eff_data;
        data_we   = 1'b0;
        priority if (!id_ok)
        begin
            res_hit = 1'b0;
        end
        else if ((eff_mask & me_onehot) != '0)
        begin
            res_hit = 1'b1;
            if (st1_write_reg == REQ_WRITE)
            begin
                new_data = st1_wdata_reg;
                data_we  = 1'b1;
            end
        end
        else if (st1_write_reg == REQ_WRITE)
        begin
            res_op    = BUS_GETM;
            res_inval = others;
            new_mask  = me_onehot;
            new_data  = st1_wdata_reg;
            data_we   = 1'b1;
        end
        else
        begin
            res_op    = BUS_GETS;
            res_inval = others;
            new_mask  = eff_mask & ~others;
            res_wbv   = |others;
            for (int i = NUM_CACHES - 1; i >= 0; i--)
            begin
                if (others[i])
                begin
                    res_wbs = ID_BITS'(i);
                end
            end
            res_wbd = res_wbv ? eff_data : '0;
        end
    end

    assign mask_we      = clearing_reg || (st1_go && id_ok);
    assign mask_wr_addr = clearing_reg ? clr_cnt_reg : st1_addr_reg;
    assign mask_wr_data = clearing_reg ? '0 : new_mask;

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_wr_addr] <= mask_wr_data;
        end
        if (st1_go && data_we)
        begin
            data_mem[st1_addr_reg] <= new_data;
        end
        if (accept)
        begin
            mask_rd_reg <= mask_mem[in_addr];
            data_rd_reg <= data_mem[in_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            st1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                st1_valid_reg <= 1'b1;
                // The row read at this edge misses the write-back of the request ahead.
                fwd_valid_reg <= st1_go && (in_addr == st1_addr_reg);
            end
            else if (st1_go)
            begin
                st1_valid_reg <= 1'b0;
            end
            if (st1_go)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st1_write_reg <= in_write;
            st1_id_reg    <= in_id;
            st1_addr_reg  <= in_addr;
            st1_wdata_reg <= in_wdata;
            fwd_mask_reg  <= new_mask;
            fwd_data_reg  <= new_data;
        end
        if (st1_go)
        begin
            m_tdata_reg <= M_TDATA_W'({res_inval, res_wbd, res_wbs, res_wbv, res_op, res_hit});
        end
    end

    `MIS_ASSERT(a_no_accept_clearing, clk, rst_n, clearing_reg |-> !s_tready, "request taken during clearing pass")
    `MIS_ASSERT(a_hit_quiet, clk, rst_n, (m_tvalid_reg && m_tdata_reg[0]) |-> (m_tdata_reg[2:1] == BUS_NONE && m_tdata_reg[4 + ID_BITS + DATA_BITS +: NUM_CACHES] == '0), "hit result carries bus activity")
    `MIS_ASSERT(a_wb_invalidates, clk, rst_n, (m_tvalid_reg && m_tdata_reg[3]) |-> (((m_tdata_reg[4 + ID_BITS + DATA_BITS +: NUM_CACHES] >> m_tdata_reg[4 +: ID_BITS]) & NUM_CACHES'(1)) != '0), "writeback source not invalidated")

endmodule

`default_nettype wire
